// File: rtl/assert_macros.svh
// Assertion macros shared by the commutation timer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/bct_pkg.sv
// Package with types and constants of the commutation timer.
package bct_pkg;

    localparam int CounterWidthDefault = 16;
    localparam int FieldWidth          = 16;

    localparam logic [3:0] ActTick         = 4'd0;
    localparam logic [3:0] ActCapture      = 4'd1;
    localparam logic [3:0] ActWritePeriod  = 4'd2;
    localparam logic [3:0] ActRestart      = 4'd3;
    localparam logic [3:0] ActMarkPrev     = 4'd4;
    localparam logic [3:0] ActRestartCapt  = 4'd5;
    localparam logic [3:0] ActArm          = 4'd6;
    localparam logic [3:0] ActClearTrigger = 4'd7;
    localparam logic [3:0] ActSoftReset    = 4'd8;

    typedef struct packed {
        logic [3:0]            action;
        logic [FieldWidth-1:0] new_period;
        logic                  arm_continuous;
        logic                  arm_once;
    } t_in_word;

    typedef struct packed {
        logic                  commutate;
        logic                  trigger_flag;
        logic [FieldWidth-1:0] counter_value;
        logic [FieldWidth-1:0] compare_value;
        logic [FieldWidth-1:0] last_capture;
        logic [FieldWidth-1:0] recent_stamp;
        logic [FieldWidth-1:0] older_stamp;
        logic [31:0]           captured_overflows;
    } t_out_word;

endpackage

// File: rtl/bct_engine.sv
// Timer state and its combinational next-state update for one input word.
`include "assert_macros.svh"

module bct_engine #(
    parameter int COUNTER_WIDTH = bct_pkg::CounterWidthDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  bct_pkg::t_in_word  i_word,
    output bct_pkg::t_out_word o_result
);

    localparam int CW = COUNTER_WIDTH;
    localparam logic [CW-1:0] FullScale = CW'(32'h0000_FFFF);
    localparam logic [31:0]   OvfMax    = 32'hFFFF_FFFF;

    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_cmp, n_cmp;
    logic [CW-1:0] r_period, n_period;
    logic [CW-1:0] r_base, n_base;
    logic [CW-1:0] r_curr, n_curr;
    logic [CW-1:0] r_prev, n_prev;
    logic [CW-1:0] r_pend, n_pend;
    logic [31:0]   r_run_ovf, n_run_ovf;
    logic [31:0]   r_lat_ovf, n_lat_ovf;
    logic          r_cont, n_cont;
    logic          r_once, n_once;
    logic          r_sticky, n_sticky;
    logic          pulse;
    logic [CW-1:0] cnt_inc;
    logic [CW-1:0] new_period;

    assign cnt_inc    = r_cnt + 1'b1;
    assign new_period = CW'(i_word.new_period);

    always_comb begin
        n_cnt     = r_cnt;
        n_cmp     = r_cmp;
        n_period  = r_period;
        n_base    = r_base;
        n_curr    = r_curr;
        n_prev    = r_prev;
        n_pend    = r_pend;
        n_run_ovf = r_run_ovf;
        n_lat_ovf = r_lat_ovf;
        n_cont    = r_cont;
        n_once    = r_once;
        n_sticky  = r_sticky;
        pulse     = 1'b0;
        case (i_word.action)
            bct_pkg::ActTick: begin
                n_cnt = cnt_inc;
                if (cnt_inc == '0 && r_run_ovf != OvfMax) begin
                    n_run_ovf = r_run_ovf + 32'd1;
                end
                if (cnt_inc == r_cmp) begin
                    n_base   = r_cmp;
                    pulse    = r_cont | r_once;
                    n_once   = 1'b0;
                    n_sticky = 1'b1;
                    n_cmp    = r_cmp + {r_period[CW-2:0], 1'b0};
                end
            end
            bct_pkg::ActCapture: begin
                n_prev    = r_pend;
                n_curr    = r_cnt;
                n_pend    = r_cnt;
                n_lat_ovf = r_run_ovf;
                n_run_ovf = '0;
            end
            bct_pkg::ActWritePeriod: begin
                n_period = new_period;
                n_cmp    = r_base + new_period;
            end
            bct_pkg::ActRestart: begin
                n_base = r_cnt;
                n_cmp  = r_cnt + r_period;
            end
            bct_pkg::ActMarkPrev: begin
                n_pend = r_cnt;
            end
            bct_pkg::ActRestartCapt: begin
                n_base    = r_cnt;
                n_cmp     = r_cnt + r_period;
                n_prev    = r_pend;
                n_curr    = r_cnt;
                n_pend    = r_cnt;
                n_lat_ovf = r_run_ovf;
                n_run_ovf = '0;
            end
            bct_pkg::ActArm: begin
                n_cont = i_word.arm_continuous;
                n_once = i_word.arm_once;
            end
            bct_pkg::ActClearTrigger: begin
                n_sticky = 1'b0;
            end
            bct_pkg::ActSoftReset: begin
                n_cont   = 1'b0;
                n_once   = 1'b0;
                n_period = FullScale;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_cmp     <= FullScale;
            r_period  <= FullScale;
            r_base    <= '0;
            r_curr    <= '0;
            r_prev    <= '0;
            r_pend    <= '0;
            r_run_ovf <= '0;
            r_lat_ovf <= '0;
            r_cont    <= 1'b0;
            r_once    <= 1'b0;
            r_sticky  <= 1'b0;
        end else if (i_step) begin
            r_cnt     <= n_cnt;
            r_cmp     <= n_cmp;
            r_period  <= n_period;
            r_base    <= n_base;
            r_curr    <= n_curr;
            r_prev    <= n_prev;
            r_pend    <= n_pend;
            r_run_ovf <= n_run_ovf;
            r_lat_ovf <= n_lat_ovf;
            r_cont    <= n_cont;
            r_once    <= n_once;
            r_sticky  <= n_sticky;
        end
    end

    always_comb begin
        o_result.commutate          = pulse;
        o_result.trigger_flag       = n_sticky;
        o_result.counter_value      = bct_pkg::FieldWidth'(n_cnt);
        o_result.compare_value      = bct_pkg::FieldWidth'(n_cmp);
        o_result.last_capture       = bct_pkg::FieldWidth'(n_base);
        o_result.recent_stamp       = bct_pkg::FieldWidth'(n_curr);
        o_result.older_stamp        = bct_pkg::FieldWidth'(n_prev);
        o_result.captured_overflows = n_lat_ovf;
    end

    `ASSERT_NEXT(a_tick_advances, i_clk, i_rst_n,
        i_step && i_word.action == bct_pkg::ActTick, r_cnt == $past(r_cnt) + 1'b1)
    `ASSERT_NEXT(a_other_holds_count, i_clk, i_rst_n,
        i_step && i_word.action != bct_pkg::ActTick, r_cnt == $past(r_cnt))
    `ASSERT_SAME(a_pulse_needs_arm, i_clk, i_rst_n, pulse, r_cont || r_once)

endmodule

// File: rtl/bldc_commutation_timer_top.sv
// Top level of the commutation timer: input register, engine and result register.
//
//  Channel  Valid        Ready        Word
//  in       i_in_valid   o_in_ready   i_in_word  (bct_pkg::t_in_word)
//  out      o_out_valid  i_out_ready  o_out_word (bct_pkg::t_out_word)
//
// An accepted word sits in the input register while the timer update runs, and its result
// loads into the result register when the output is free. One word per cycle is sustained
// when the output does not stall; the timer state update is the single stage that sets it.
// Reset is synchronous and active low; it returns every timer register to its start value.
// A stalled output holds the result register, and the input register fills behind it.
`include "assert_macros.svh"

module bldc_commutation_timer_top #(
    parameter int COUNTER_WIDTH = bct_pkg::CounterWidthDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bct_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bct_pkg::t_out_word o_out_word
);

    logic               r_in_valid;
    bct_pkg::t_in_word  r_in_word;
    logic               r_out_valid;
    bct_pkg::t_out_word r_out_word;
    logic               step;
    bct_pkg::t_out_word result;

    assign step       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    bct_engine #(
        .COUNTER_WIDTH(COUNTER_WIDTH)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_word   (r_in_word),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_word <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `ASSERT_NEXT(a_step_gives_result, i_clk, i_rst_n, step, r_out_valid)
    `ASSERT_SAME(a_commutate_sets_flag, i_clk, i_rst_n,
        r_out_valid && r_out_word.commutate, r_out_word.trigger_flag)
    `ASSERT_NEXT(a_stall_keeps_input, i_clk, i_rst_n, r_in_valid && !step, r_in_valid)

endmodule
